// File: design/swhd_pkg.sv
// shared types and constants of the single-wire half-duplex serial port
`timescale 1ns / 1ps

package swhd_pkg;

	localparam int unsigned CfgWidth = 16;
	localparam int unsigned ByteWidth = 8;
	localparam logic [CfgWidth-1:0] BitPeriodReset = 16'd256;

	localparam logic [1:0] FN_TICK   = 2'd0;
	localparam logic [1:0] FN_ARM_TX = 2'd1;
	localparam logic [1:0] FN_ARM_RX = 2'd2;

	typedef enum logic [8:0] {
		PH_IDLE      = 9'b000000001,
		PH_TX_ARMED  = 9'b000000010,
		PH_TX_HALF   = 9'b000000100,
		PH_TX_PULLUP = 9'b000001000,
		PH_TX_HIGH   = 9'b000010000,
		PH_TX_DATA   = 9'b000100000,
		PH_RX_ARMED  = 9'b001000000,
		PH_RX_HALF   = 9'b010000000,
		PH_RX_DATA   = 9'b100000000
	} phase_t;

	typedef struct packed {
		logic                 drive_enable;
		logic                 drive_level;
		logic                 pullup_enable;
		logic                 busy_res;
		logic                 tx_done;
		logic                 rx_valid;
		logic [ByteWidth-1:0] rx_byte;
	} res_t;

endpackage

// File: design/swhd_if.sv
// handshake channels for commands and status of the serial port
`timescale 1ns / 1ps

interface swhd_cmd_if;
	logic       valid;
	logic       ready;
	logic [1:0] func;
	logic [7:0] tx_byte;
	logic       line_level;

	modport source (output valid, func, tx_byte, line_level, input ready);
	modport sink (input valid, func, tx_byte, line_level, output ready);
endinterface

interface swhd_res_if;
	logic       valid;
	logic       ready;
	logic       drive_enable;
	logic       drive_level;
	logic       pullup_enable;
	logic       busy_res;
	logic       tx_done;
	logic       rx_valid;
	logic [7:0] rx_byte;

	modport source (output valid, drive_enable, drive_level, pullup_enable, busy_res,
		tx_done, rx_valid, rx_byte, input ready);
	modport sink (input valid, drive_enable, drive_level, pullup_enable, busy_res,
		tx_done, rx_valid, rx_byte, output ready);
endinterface

// File: design/single_wire_half_duplex_serial.sv
// top level of the single-wire half-duplex serial port
// usage:
//   cmd carries one item per transfer: a timer tick with the sampled wire
//   level, an arm-transmit command with the byte to send, or an arm-receive
//   command. res returns exactly one status item per command item: wire
//   drive enable and level, pull-up enable, busy, tx_done and rx_valid
//   pulses and the received byte.
//   cfg_we / cfg_wdata load the bit period in ticks; write it only while idle.
//   the status for an item is on res in the cycle after the item's
//   transfer. one item is taken every cycle while res is free or being
//   taken; the single result register sets that rate.
//   when res stalls with a result pending, cmd.ready drops and no item is
//   taken until the result leaves.
//   reset leaves the port idle with the wire released, pull-up off and a
//   bit period of 256 ticks; the result register comes up empty.
`timescale 1ns / 1ps

module single_wire_half_duplex_serial #(
	parameter int unsigned DATA_BITS = 8,
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [swhd_pkg::CfgWidth-1:0] cfg_wdata,
	swhd_cmd_if.sink                      cmd,
	swhd_res_if.source                    res
);
	import swhd_pkg::*;

	logic room;
	logic take;
	res_t res_d;

	assign cmd.ready = room;
	assign take      = cmd.valid && room;

	swhd_core #(
		.DATA_BITS   (DATA_BITS),
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.take       (take),
		.func       (cmd.func),
		.tx_byte    (cmd.tx_byte),
		.line_level (cmd.line_level),
		.res        (res_d)
	);

	swhd_out_reg u_out_reg (
		.clk    (clk),
		.arst_n (arst_n),
		.take   (take),
		.res    (res_d),
		.room   (room),
		.out    (res)
	);

endmodule

// File: design/swhd_core.sv
// bit timing state machine: one command or timer tick per cycle while take is high
`timescale 1ns / 1ps

module swhd_core #(
	parameter int unsigned DATA_BITS = 8,
	parameter int unsigned TIMER_WIDTH = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [swhd_pkg::CfgWidth-1:0]      cfg_wdata,
	input  logic                               take,
	input  logic [1:0]                         func,
	input  logic [swhd_pkg::ByteWidth-1:0]     tx_byte,
	input  logic                               line_level,
	output swhd_pkg::res_t                     res
);
	import swhd_pkg::*;

	localparam int unsigned IdxWidth = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
	localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(DATA_BITS - 1);

	logic [CfgWidth-1:0]    bit_period_q;
	phase_t                 phase_q, phase_d;
	logic [TIMER_WIDTH-1:0] cnt_q, cnt_d, cnt_dec, full_load, half_load;
	logic [IdxWidth-1:0]    idx_q, idx_d;
	logic [DATA_BITS-1:0]   shift_q, shift_d, shift_tx;
	logic                   drive_q, drive_d, level_q, level_d, pullup_q, pullup_d;
	logic                   tx_done_d, rx_valid_d;
	logic [31:0]            bp_wide, half_wide, tx_wide, sh_wide;

	// a count of zero after truncation still lasts one tick
	always_comb begin
		bp_wide   = 32'(bit_period_q);
		half_wide = 32'(bit_period_q >> 1);
		full_load = bp_wide[TIMER_WIDTH-1:0];
		half_load = half_wide[TIMER_WIDTH-1:0];
		if (full_load == '0) full_load = TIMER_WIDTH'(1);
		if (half_load == '0) half_load = TIMER_WIDTH'(1);
		tx_wide   = 32'(tx_byte);
		shift_tx  = tx_wide[DATA_BITS-1:0];
	end

	always_comb begin
		phase_d    = phase_q;
		cnt_d      = cnt_q;
		idx_d      = idx_q;
		shift_d    = shift_q;
		drive_d    = drive_q;
		level_d    = level_q;
		pullup_d   = pullup_q;
		tx_done_d  = 1'b0;
		rx_valid_d = 1'b0;
		cnt_dec    = cnt_q - TIMER_WIDTH'(1);
		if (func == FN_ARM_TX || func == FN_ARM_RX) begin
			// arming aborts whatever is in flight
			drive_d  = 1'b0;
			level_d  = 1'b0;
			pullup_d = 1'b0;
			cnt_d    = '0;
			idx_d    = '0;
			if (func == FN_ARM_TX) begin
				shift_d = shift_tx;
				phase_d = PH_TX_ARMED;
			end else begin
				shift_d = '0;
				phase_d = PH_RX_ARMED;
			end
		end else if (func == FN_TICK) begin
			if (phase_q == PH_TX_ARMED || phase_q == PH_RX_ARMED) begin
				if (!line_level) begin
					cnt_d   = half_load;
					phase_d = (phase_q == PH_TX_ARMED) ? PH_TX_HALF : PH_RX_HALF;
				end
			end else if (phase_q != PH_IDLE) begin
				cnt_d = cnt_dec;
				if (cnt_dec == '0) begin
					unique case (phase_q)
						PH_TX_HALF: begin
							pullup_d = 1'b1;
							cnt_d    = full_load;
							phase_d  = PH_TX_PULLUP;
						end
						PH_TX_PULLUP: begin
							pullup_d = 1'b1;
							drive_d  = 1'b1;
							level_d  = 1'b1;
							cnt_d    = full_load;
							phase_d  = PH_TX_HIGH;
						end
						PH_TX_HIGH: begin
							pullup_d = 1'b1;
							drive_d  = 1'b1;
							level_d  = shift_q[DATA_BITS-1];
							shift_d  = shift_q << 1;
							idx_d    = '0;
							cnt_d    = full_load;
							phase_d  = PH_TX_DATA;
						end
						PH_TX_DATA: begin
							if (idx_q >= LastIdx) begin
								drive_d   = 1'b0;
								level_d   = 1'b0;
								pullup_d  = 1'b0;
								idx_d     = '0;
								tx_done_d = 1'b1;
								phase_d   = PH_IDLE;
							end else begin
								pullup_d = 1'b1;
								drive_d  = 1'b1;
								level_d  = shift_q[DATA_BITS-1];
								shift_d  = shift_q << 1;
								idx_d    = idx_q + IdxWidth'(1);
								cnt_d    = full_load;
							end
						end
						PH_RX_HALF: begin
							idx_d   = '0;
							cnt_d   = full_load;
							phase_d = PH_RX_DATA;
						end
						PH_RX_DATA: begin
							shift_d = (shift_q << 1) | DATA_BITS'(line_level);
							if (idx_q >= LastIdx) begin
								idx_d      = '0;
								rx_valid_d = 1'b1;
								phase_d    = PH_IDLE;
							end else begin
								idx_d = idx_q + IdxWidth'(1);
								cnt_d = full_load;
							end
						end
						default: begin
							phase_d  = PH_IDLE;
							drive_d  = 1'b0;
							level_d  = 1'b0;
							pullup_d = 1'b0;
						end
					endcase
				end
			end
		end
	end

	// status reflects the state left by this transfer
	always_comb begin
		sh_wide           = 32'(shift_d);
		res.drive_enable  = drive_d;
		res.drive_level   = drive_d & level_d;
		res.pullup_enable = pullup_d;
		res.busy_res      = (phase_d != PH_IDLE);
		res.tx_done       = tx_done_d;
		res.rx_valid      = rx_valid_d;
		if (phase_d == PH_TX_ARMED || phase_d == PH_TX_HALF || phase_d == PH_TX_PULLUP ||
		    phase_d == PH_TX_HIGH || phase_d == PH_TX_DATA)
			res.rx_byte = '0;
		else
			res.rx_byte = sh_wide[ByteWidth-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q <= BitPeriodReset;
		end else if (cfg_we) begin
			bit_period_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_IDLE;
			cnt_q    <= '0;
			idx_q    <= '0;
			shift_q  <= '0;
			drive_q  <= 1'b0;
			level_q  <= 1'b0;
			pullup_q <= 1'b0;
		end else if (take) begin
			phase_q  <= phase_d;
			cnt_q    <= cnt_d;
			idx_q    <= idx_d;
			shift_q  <= shift_d;
			drive_q  <= drive_d;
			level_q  <= level_d;
			pullup_q <= pullup_d;
		end
	end

endmodule

// File: design/swhd_out_reg.sv
// result register between the state machine and the status channel
`timescale 1ns / 1ps

module swhd_out_reg (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            take,
	input  swhd_pkg::res_t  res,
	output logic            room,
	swhd_res_if.source      out
);
	import swhd_pkg::*;

	logic valid_q;
	res_t res_q;

	// a new transfer can load the register in the cycle the old one leaves
	assign room = !valid_q || out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (room) begin
			valid_q <= take;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= res;
		end
	end

	assign out.valid         = valid_q;
	assign out.drive_enable  = res_q.drive_enable;
	assign out.drive_level   = res_q.drive_level;
	assign out.pullup_enable = res_q.pullup_enable;
	assign out.busy_res      = res_q.busy_res;
	assign out.tx_done       = res_q.tx_done;
	assign out.rx_valid      = res_q.rx_valid;
	assign out.rx_byte       = res_q.rx_byte;

endmodule
